/* rtl/gpr_pkg.sv */
package gpr_pkg;

    localparam int GLYPH_W    = 5;
    localparam int GLYPH_H    = 7;
    localparam int GLYPH_DOTS = GLYPH_W * GLYPH_H;
    localparam int COL_W      = $clog2(GLYPH_W);
    localparam int ROW_W      = $clog2(GLYPH_H);
    localparam int FONT_N     = 96;

    localparam logic [7:0] CODE_FIRST = 8'h20;
    localparam logic [7:0] CODE_LAST  = 8'h7F;
    localparam logic [7:0] CHECK_EVEN = 8'hAA;
    localparam logic [7:0] CHECK_ODD  = 8'h55;

    typedef logic [COL_W-1:0]      t_col;
    typedef logic [ROW_W-1:0]      t_row;
    typedef logic [GLYPH_DOTS-1:0] t_glyph;

    // Status of the dot scanner as seen by the top level.
    typedef struct packed {
        logic busy;
        logic lit;
        t_col col;
        t_row row;
    } t_scan;

    // One entry per glyph, column 0 in the lowest byte.
    localparam logic [39:0] FONT [FONT_N] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
        40'h122A7F2A24, 40'h6264081323, 40'h5022554936, 40'h0000030500,
        40'h0041221C00, 40'h001C224100, 40'h082A1C2A08, 40'h08083E0808,
        40'h0000305000, 40'h0808080808, 40'h0000606000, 40'h0204081020,
        40'h3E4549513E, 40'h00407F4200, 40'h4649516142, 40'h314B454121,
        40'h107F121418, 40'h3945454527, 40'h3049494A3C, 40'h0305097101,
        40'h3649494936, 40'h1E29494906, 40'h0000363600, 40'h0000365600,
        40'h4122140800, 40'h1414141414, 40'h0008142241, 40'h0609510102,
        40'h3E41794932, 40'h7E1111117E, 40'h364949497F, 40'h224141413E,
        40'h1C2241417F, 40'h414949497F, 40'h010109097F, 40'h325141413E,
        40'h7F0808087F, 40'h00417F4100, 40'h013F414020, 40'h412214087F,
        40'h404040407F, 40'h7F0204027F, 40'h7F1008047F, 40'h3E4141413E,
        40'h060909097F, 40'h5E2151413E, 40'h462919097F, 40'h3149494946,
        40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F,
        40'h6314081463, 40'h0304780403, 40'h4345495161, 40'h41417F0000,
        40'h2010080402, 40'h00007F4141, 40'h0402010204, 40'h4040404040,
        40'h0004020100, 40'h7854545420, 40'h384444487F, 40'h2044444438,
        40'h7F48444438, 40'h1854545438, 40'h0201097E08, 40'h3C54541408,
        40'h780404087F, 40'h00407D4400, 40'h003D444020, 40'h4428107F00,
        40'h00407F4100, 40'h780418047C, 40'h780404087C, 40'h3844444438,
        40'h081414147C, 40'h7C18141408, 40'h080404087C, 40'h2054545448,
        40'h2040443F04, 40'h7C2040403C, 40'h1C2040201C, 40'h3C4030403C,
        40'h4428102844, 40'h3C5050500C, 40'h444C546444, 40'h0041360800,
        40'h00007F0000, 40'h0008364100, 40'h081C2A0808, 40'h08082A1C08
    };

    // Dot map of a glyph, column-major: bit (col * GLYPH_H + row).
    function automatic t_glyph glyph_dots(input logic [7:0] code);
        logic [39:0] entry;
        logic [6:0]  idx;
        t_glyph      dots;
        idx = 7'(code - CODE_FIRST);
        entry = FONT[idx];
        if (code inside {[CODE_FIRST:CODE_LAST]}) begin
            for (int c = 0; c < GLYPH_W; c++) begin
                dots[c*GLYPH_H +: GLYPH_H] = entry[c*8 +: GLYPH_H];
            end
        end else begin
            for (int c = 0; c < GLYPH_W; c++) begin
                dots[c*GLYPH_H +: GLYPH_H] = (c % 2 == 1) ? CHECK_ODD[GLYPH_H-1:0]
                                                          : CHECK_EVEN[GLYPH_H-1:0];
            end
        end
        return dots;
    endfunction

endpackage

/* rtl/gpr_dot_scan.sv */
module gpr_dot_scan (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  gpr_pkg::t_glyph  i_glyph,
    input  logic             i_take,
    output gpr_pkg::t_scan   o_scan
);

    localparam gpr_pkg::t_col COL_LAST = gpr_pkg::t_col'(gpr_pkg::GLYPH_W - 1);
    localparam gpr_pkg::t_row ROW_LAST = gpr_pkg::t_row'(gpr_pkg::GLYPH_H - 1);

    logic            r_busy;
    gpr_pkg::t_glyph r_dots;
    gpr_pkg::t_col   r_col;
    gpr_pkg::t_row   r_row;
    logic            w_step;

    // A dark dot is skipped at once; a lit one waits until the top level takes it.
    assign w_step = r_busy && (!r_dots[0] || i_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_load) begin
            r_busy <= 1'b1;
        end else if (w_step && r_col == COL_LAST && r_row == ROW_LAST) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_dots <= i_glyph;
            r_col  <= '0;
            r_row  <= '0;
        end else if (w_step) begin
            r_dots <= {1'b0, r_dots[gpr_pkg::GLYPH_DOTS-1:1]};
            if (r_row == ROW_LAST) begin
                r_row <= '0;
                r_col <= r_col + gpr_pkg::t_col'(1);
            end else begin
                r_row <= r_row + gpr_pkg::t_row'(1);
            end
        end
    end

    assign o_scan.busy = r_busy;
    assign o_scan.lit  = r_busy && r_dots[0];
    assign o_scan.col  = r_col;
    assign o_scan.row  = r_row;

endmodule

/* rtl/glyph_pixel_rasterizer.sv */
// 5x7 character generator. Each input beat carries a character code, the
// origin of its glyph cell and a drawing color; the block answers with one
// output beat for every lit dot of the glyph, scanned column by column from
// the left and top to bottom within a column, and marks the final dot with
// tlast. Codes 0x20 to 0x7F come from the built-in font, every other code
// draws a checker pattern, and a blank glyph such as the space gives no
// output at all. Coordinates are origin plus dot offset and are not clipped.
// The dot map is shifted out one bit per clock unless a lit dot has to wait
// for the output side, and a new glyph is accepted only after the scan and
// the release of its final dot, if any, are done. One dot is held back until
// the next lit dot or the end of the scan is found, which is how tlast is
// known in advance.
module glyph_pixel_rasterizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // char_code[7:0], origin_x[15:8], origin_y[23:16], red[31:24],
    // green[39:32], blue[47:40]
    input  logic [47:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // pixel_x[8:0], pixel_y[17:9], pixel_red[25:18], pixel_green[33:26],
    // pixel_blue[41:34], zero fill[47:42]
    output logic [47:0] o_m_tdata,
    // last_pixel
    output logic        o_m_tlast
);

    gpr_pkg::t_scan w_scan;
    logic           w_load;
    logic           w_out_free;
    logic           w_take;
    logic           w_flush;
    logic           w_push;

    // Glyph origin and color of the item being scanned.
    logic [7:0]     r_ox;
    logic [7:0]     r_oy;
    logic [7:0]     r_red;
    logic [7:0]     r_green;
    logic [7:0]     r_blue;

    // The dot found most recently, not yet known to be the last one.
    logic           r_pend_valid;
    gpr_pkg::t_col  r_pend_col;
    gpr_pkg::t_row  r_pend_row;

    // Output register.
    logic           r_out_valid;
    logic           r_out_last;
    logic [8:0]     r_out_x;
    logic [8:0]     r_out_y;
    logic [7:0]     r_out_red;
    logic [7:0]     r_out_green;
    logic [7:0]     r_out_blue;

    // A new glyph may start once the scan and the held dot are both done;
    // the output register may still hold a beat of the previous glyph.
    assign o_s_tready = !w_scan.busy && !r_pend_valid;
    assign w_load     = i_s_tvalid && o_s_tready;

    assign w_out_free = !r_out_valid || i_m_tready;

    // Take a lit dot if there is no held dot, or if the held one can move on.
    assign w_take  = w_scan.lit && (!r_pend_valid || w_out_free);
    // End of scan: the held dot is the last one of the glyph.
    assign w_flush = !w_scan.busy && r_pend_valid && w_out_free;
    assign w_push  = (w_take && r_pend_valid) || w_flush;

    gpr_dot_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_glyph (gpr_pkg::glyph_dots(i_s_tdata[7:0])),
        .i_take  (w_take),
        .o_scan  (w_scan)
    );

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_ox    <= i_s_tdata[15:8];
            r_oy    <= i_s_tdata[23:16];
            r_red   <= i_s_tdata[31:24];
            r_green <= i_s_tdata[39:32];
            r_blue  <= i_s_tdata[47:40];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_take) begin
                r_pend_valid <= 1'b1;
                r_pend_col   <= w_scan.col;
                r_pend_row   <= w_scan.row;
            end else if (w_flush) begin
                r_pend_valid <= 1'b0;
            end

            if (w_push) begin
                r_out_valid <= 1'b1;
                r_out_last  <= w_flush;
                r_out_x     <= {1'b0, r_ox} + 9'(r_pend_col);
                r_out_y     <= {1'b0, r_oy} + 9'(r_pend_row);
                r_out_red   <= r_red;
                r_out_green <= r_green;
                r_out_blue  <= r_blue;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = {6'd0, r_out_blue, r_out_green, r_out_red, r_out_y, r_out_x};

    // An accepted glyph always starts a scan.
    a_load_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> w_scan.busy)
        else $error("scan did not start after an accepted glyph");

    // A lit dot is only reported while the scan runs.
    a_lit_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_scan.lit |-> w_scan.busy)
        else $error("lit dot reported by an idle scanner");

    // Releasing the held dot at the end of the scan presents a final beat.
    a_flush_gives_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_flush |=> (o_m_tvalid && o_m_tlast))
        else $error("final dot of a glyph not marked last");

    // No new dot is taken while the held dot has nowhere to go.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_valid && r_out_valid && !i_m_tready) |-> !w_take)
        else $error("held dot overwritten while output stalled");

endmodule
